### rtl/core/b2s_pkg.sv
`default_nettype none
package b2s_pkg;

	localparam int BLOCK_BYTES  = 64;
	localparam int DIGEST_BYTES = 32;
	localparam int KEY_BYTES    = 32;
	localparam int G_STEPS      = 160;

	localparam logic [31:0] PARAM_BASE = 32'h0101_0000;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	typedef enum logic [2:0] {
		REG_DIGEST_LEN = 3'd0,
		REG_KEY_LEN    = 3'd1,
		REG_KEY_0      = 3'd2,
		REG_KEY_1      = 3'd3,
		REG_KEY_2      = 3'd4,
		REG_KEY_3      = 3'd5
	} reg_idx_t;

	typedef enum logic [0:0] {
		ACT_APPEND = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOAD,
		ST_RUN,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// message word schedule, position 0 in the low nibble
	function automatic logic [3:0] msg_sel(input logic [3:0] rnd, input logic [3:0] pos);
		logic [63:0] row;
		case (rnd)
			4'd0: row = 64'hFEDCBA9876543210;
			4'd1: row = 64'h357B20C16DF984AE;
			4'd2: row = 64'h491763EADF250C8B;
			4'd3: row = 64'h8F04A562EBCD1397;
			4'd4: row = 64'hD386CB1EFA427509;
			4'd5: row = 64'h91EF57D438B0A6C2;
			4'd6: row = 64'hB8293670A4DEF15C;
			4'd7: row = 64'hA2684F05931CE7BD;
			4'd8: row = 64'h5A417D2C803B9EF6;
			4'd9: row = 64'h0DC3E9BF5167482A;
			default: row = 64'h0;
		endcase
		return row[{pos, 2'b00} +: 4];
	endfunction

endpackage
`default_nettype wire

### rtl/core/blake2s_hash_engine_top.sv
// Append item: accept, then dispatch; accepting a byte onto a full block adds a
// compression (load, 160 half-G steps on one shared G unit, fold).
// Finish item: accept, dispatch and a compression, then one digest byte per cycle while out_ready is high.
// One item at a time; in_ready is high only when the engine is idle.
// Reset: asynchronous, active low; config returns to digest length 32, unkeyed, zero key,
// and the next item starts a new message. The block buffer is not cleared.
`default_nettype none
module blake2s_hash_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [63:0] wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       digest_byte,
	output logic             last_byte
);
	import b2s_pkg::*;

	state_t      state_q, state_nxt;
	logic [5:0]  dl_cfg_q, kl_cfg_q;
	logic [63:0] key_q [4];

	logic [31:0] chain_q [8];
	logic [31:0] v_q [16];
	logic [63:0] ctr_q;
	logic [6:0]  fill_q;
	logic        fresh_q;
	logic        key_src_q;
	logic        final_q;
	logic [5:0]  dl_q;
	logic [5:0]  kl_q;
	logic        act_q;
	logic [7:0]  byte_q;
	logic [7:0]  step_q;
	logic [4:0]  idx_q;

	logic [31:0] mem [16];
	logic [31:0] mem_rd_q;
	logic [3:0]  rd_addr, rd_addr_q;
	logic        mem_we;
	logic [3:0]  mem_wa;
	logic [1:0]  mem_lane;

	logic        in_acc, out_acc, run_done, emit_last;
	logic [5:0]  dl_sat, kl_sat;
	logic [7:0]  step_inc;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign run_done  = (step_q == 8'(G_STEPS - 1));
	assign step_inc  = step_q + 8'd1;
	assign emit_last = ({1'b0, idx_q} + 6'd1 == dl_q);

	always_comb begin
		dl_sat = dl_cfg_q;
		if (dl_cfg_q == 6'd0) dl_sat = 6'd1;
		else if (dl_cfg_q > 6'(DIGEST_BYTES)) dl_sat = 6'(DIGEST_BYTES);
		kl_sat = (kl_cfg_q > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : kl_cfg_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_acc) state_nxt = ST_DISPATCH;
			ST_DISPATCH: begin
				if (act_q == ACT_FINISH || fill_q == 7'(BLOCK_BYTES)) state_nxt = ST_LOAD;
				else state_nxt = ST_IDLE;
			end
			ST_LOAD:     state_nxt = ST_RUN;
			ST_RUN:      if (run_done) state_nxt = ST_FOLD;
			ST_FOLD:     state_nxt = final_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:     if (out_acc && emit_last) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
	end

	assign digest_byte = chain_q[idx_q[4:2]][{idx_q[1:0], 3'b000} +: 8];
	assign last_byte   = emit_last;

	// message word fetch and padding mask
	assign rd_addr = (state_q == ST_RUN) ? msg_sel(step_inc[7:4], {step_inc[3:1], step_inc[0]})
	                                     : 4'd0;

	logic [31:0] msg_word;
	always_comb begin
		logic [31:0] raw;
		logic [6:0]  len;
		// two message words per 64-bit key register
		raw = key_src_q ? key_q[rd_addr_q[2:1]][{rd_addr_q[0], 5'b00000} +: 32] : mem_rd_q;
		len = key_src_q ? {1'b0, kl_q} : fill_q;
		for (int b = 0; b < 4; b++) begin
			msg_word[b*8 +: 8] = ({1'b0, rd_addr_q, 2'(b)} < len) ? raw[b*8 +: 8] : 8'h00;
		end
	end

	// shared G unit: half a G per cycle on fixed slots 0, 4, 8, 12, then rotate rows
	logic [31:0] v_nxt [16];
	always_comb begin
		logic [31:0] a1, b1, c1, d1, td, tb;
		logic [31:0] v_tmp [16];
		logic [1:0]  k [4];
		logic [1:0]  col;
		a1 = v_q[0] + v_q[4] + msg_word;
		td = v_q[12] ^ a1;
		d1 = step_q[0] ? {td[7:0], td[31:8]} : {td[15:0], td[31:16]};
		c1 = v_q[8] + d1;
		tb = v_q[4] ^ c1;
		b1 = step_q[0] ? {tb[6:0], tb[31:7]} : {tb[11:0], tb[31:12]};
		for (int i = 0; i < 16; i++) v_tmp[i] = v_q[i];
		v_tmp[0]  = a1;
		v_tmp[4]  = b1;
		v_tmp[8]  = c1;
		v_tmp[12] = d1;
		k[0] = 2'd1; k[1] = 2'd1; k[2] = 2'd1; k[3] = 2'd1;
		if (step_q[3:1] == 3'd3) begin
			k[1] = 2'd2; k[2] = 2'd3; k[3] = 2'd0;
		end else if (step_q[3:1] == 3'd7) begin
			k[1] = 2'd0; k[2] = 2'd3; k[3] = 2'd2;
		end
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				col = 2'(j) + k[r];
				v_nxt[r*4 + j] = step_q[0] ? v_tmp[{2'(r), col}] : v_tmp[r*4 + j];
			end
		end
	end

	// buffer write: appended byte, or the held byte at slot 0 after a full block
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = fill_q[5:2];
		mem_lane = fill_q[1:0];
		if (state_q == ST_DISPATCH && act_q == ACT_APPEND && fill_q != 7'(BLOCK_BYTES))
			mem_we = 1'b1;
		if (state_q == ST_FOLD && !final_q) begin
			mem_we   = 1'b1;
			mem_wa   = 4'd0;
			mem_lane = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa][{mem_lane, 3'b000} +: 8] <= byte_q;
		mem_rd_q  <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dl_cfg_q <= 6'(DIGEST_BYTES);
			kl_cfg_q <= 6'd0;
			for (int i = 0; i < 4; i++) key_q[i] <= 64'd0;
			ctr_q     <= 64'd0;
			fill_q    <= 7'd0;
			fresh_q   <= 1'b1;
			key_src_q <= 1'b0;
			final_q   <= 1'b0;
			dl_q      <= 6'(DIGEST_BYTES);
			kl_q      <= 6'd0;
			step_q    <= 8'd0;
			idx_q     <= 5'd0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				case (wr_index)
					REG_DIGEST_LEN: dl_cfg_q <= wr_data[5:0];
					REG_KEY_LEN:    kl_cfg_q <= wr_data[5:0];
					REG_KEY_0:      key_q[0] <= wr_data;
					REG_KEY_1:      key_q[1] <= wr_data;
					REG_KEY_2:      key_q[2] <= wr_data;
					REG_KEY_3:      key_q[3] <= wr_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && fresh_q) begin
						fresh_q   <= 1'b0;
						ctr_q     <= 64'd0;
						dl_q      <= dl_sat;
						kl_q      <= kl_sat;
						key_src_q <= (kl_sat != 6'd0);
						fill_q    <= (kl_sat != 6'd0) ? 7'(BLOCK_BYTES) : 7'd0;
					end
				end
				ST_DISPATCH: begin
					if (act_q == ACT_FINISH) begin
						ctr_q   <= ctr_q + 64'(fill_q);
						final_q <= 1'b1;
					end else if (fill_q == 7'(BLOCK_BYTES)) begin
						ctr_q   <= ctr_q + 64'(BLOCK_BYTES);
						final_q <= 1'b0;
					end else begin
						fill_q <= fill_q + 7'd1;
					end
					step_q <= 8'd0;
				end
				ST_RUN: step_q <= run_done ? 8'd0 : step_inc;
				ST_FOLD: begin
					if (final_q) begin
						idx_q <= 5'd0;
					end else begin
						fill_q    <= 7'd1;
						key_src_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						idx_q <= idx_q + 5'd1;
						if (emit_last) fresh_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= action;
			byte_q <= data_byte;
		end
		if (state_q == ST_IDLE && in_acc && fresh_q) begin
			for (int i = 1; i < 8; i++) chain_q[i] <= IV[i];
			chain_q[0] <= IV[0] ^ PARAM_BASE ^ {18'd0, kl_sat, 2'b00, dl_sat};
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
			for (int i = 0; i < 4; i++) v_q[8 + i] <= IV[i];
			v_q[12] <= IV[4] ^ ctr_q[31:0];
			v_q[13] <= IV[5] ^ ctr_q[63:32];
			v_q[14] <= final_q ? (IV[6] ^ ALL_ONES) : IV[6];
			v_q[15] <= IV[7];
		end
		if (state_q == ST_RUN) begin
			for (int i = 0; i < 16; i++) v_q[i] <= v_nxt[i];
		end
		if (state_q == ST_FOLD) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i + 8];
		end
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in_ready while digest pending");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 7'(BLOCK_BYTES)) else $error("fill count overflow");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < 8'(G_STEPS)) else $error("G step out of range");
	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, idx_q} < dl_q)) else $error("digest index past length");
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_byte) |=> (in_ready && fresh_q)) else $error("message not closed");

endmodule
`default_nettype wire

### test/blake2s_hash_engine_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module blake2s_hash_engine_top_tb;
	import b2s_pkg::*;

	localparam logic [2:0] REG_UNUSED_6 = 3'd6;
	localparam logic [2:0] REG_UNUSED_7 = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 310;

	class digest_scoreboard;
		logic [5:0]  dl_reg;
		logic [5:0]  kl_reg;
		logic [63:0] key_reg [4];
		logic [31:0] chain [8];
		logic [63:0] count;
		logic [7:0]  blk [64];
		int          fill;
		bit          fresh;
		int          held_len;
		logic [31:0] v [16];
		logic [3:0]  sched [10][16];
		logic [8:0]  digest_q [$];
		int          errors;

		function new();
			sched = '{
				'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
				'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
				'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
				'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
				'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
				'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
				'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
				'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
				'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
				'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
			};
			dl_reg = 6'd32;
			kl_reg = 6'd0;
			foreach (key_reg[i]) key_reg[i] = 64'd0;
			foreach (chain[i]) chain[i] = 32'd0;
			foreach (blk[i]) blk[i] = 8'd0;
			count = 64'd0;
			fill = 0;
			fresh = 1'b1;
			held_len = DIGEST_BYTES;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] data);
			case (idx)
				REG_DIGEST_LEN: dl_reg = data[5:0];
				REG_KEY_LEN:    kl_reg = data[5:0];
				REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: key_reg[idx - REG_KEY_0] = data;
				default: ;
			endcase
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void quarter(int a, int b, int c, int d, logic [31:0] x, logic [31:0] y);
			v[a] = v[a] + v[b] + x;
			v[d] = ror(v[d] ^ v[a], 16);
			v[c] = v[c] + v[d];
			v[b] = ror(v[b] ^ v[c], 12);
			v[a] = v[a] + v[b] + y;
			v[d] = ror(v[d] ^ v[a], 8);
			v[c] = v[c] + v[d];
			v[b] = ror(v[b] ^ v[c], 7);
		endfunction

		function void compress(bit last_blk);
			logic [31:0] m [16];
			for (int i = 0; i < 16; i++)
				m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
			for (int i = 0; i < 8; i++) begin
				v[i] = chain[i];
				v[i+8] = IV[i];
			end
			v[12] ^= count[31:0];
			v[13] ^= count[63:32];
			if (last_blk) v[14] ^= ALL_ONES;
			for (int r = 0; r < 10; r++) begin
				quarter(0, 4, 8, 12, m[sched[r][0]], m[sched[r][1]]);
				quarter(1, 5, 9, 13, m[sched[r][2]], m[sched[r][3]]);
				quarter(2, 6, 10, 14, m[sched[r][4]], m[sched[r][5]]);
				quarter(3, 7, 11, 15, m[sched[r][6]], m[sched[r][7]]);
				quarter(0, 5, 10, 15, m[sched[r][8]], m[sched[r][9]]);
				quarter(1, 6, 11, 12, m[sched[r][10]], m[sched[r][11]]);
				quarter(2, 7, 8, 13, m[sched[r][12]], m[sched[r][13]]);
				quarter(3, 4, 9, 14, m[sched[r][14]], m[sched[r][15]]);
			end
			for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
		endfunction

		function void open_message();
			int dl;
			int kl;
			dl = dl_reg;
			kl = kl_reg;
			if (dl < 1) dl = 1;
			if (dl > DIGEST_BYTES) dl = DIGEST_BYTES;
			if (kl > KEY_BYTES) kl = KEY_BYTES;
			for (int i = 0; i < 8; i++) chain[i] = IV[i];
			chain[0] ^= PARAM_BASE ^ (32'(kl) << 8) ^ 32'(dl);
			count = 64'd0;
			fill = 0;
			if (kl > 0) begin
				for (int i = 0; i < BLOCK_BYTES; i++)
					blk[i] = (i < kl) ? key_reg[i >> 3][8*(i & 7) +: 8] : 8'd0;
				fill = BLOCK_BYTES;
			end
			held_len = dl;
			fresh = 1'b0;
		endfunction

		function void note_input(action_t act, logic [7:0] data);
			if (fresh) open_message();
			if (act == ACT_APPEND) begin
				if (fill >= BLOCK_BYTES) begin
					count += BLOCK_BYTES;
					compress(1'b0);
					fill = 0;
				end
				blk[fill] = data;
				fill++;
			end else begin
				count += 64'(fill);
				for (int i = fill; i < BLOCK_BYTES; i++) blk[i] = 8'd0;
				compress(1'b1);
				for (int i = 0; i < held_len; i++)
					digest_q.push_back({(i + 1 == held_len), chain[i >> 2][8*(i & 3) +: 8]});
				fresh = 1'b1;
			end
		endfunction

		task report(string what, logic [8:0] got, logic [8:0] want);
			errors++;
			$display("mismatch %s: got %h want %h", what, got, want);
		endtask

		task check_result(logic [7:0] dbyte, logic lbyte);
			logic [8:0] want;
			if (digest_q.size() == 0) begin
				report("unexpected digest byte", {lbyte, dbyte}, 9'h0);
			end else begin
				want = digest_q.pop_front();
				if (dbyte !== want[7:0]) report("digest_byte", {1'b0, dbyte}, {1'b0, want[7:0]});
				if (lbyte !== want[8]) report("last_byte", {8'd0, lbyte}, {8'd0, want[8]});
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  digest_byte;
	logic        last_byte;

	digest_scoreboard sb;
	int  cycles;
	int  items_sent;
	bit  calm;

	blake2s_hash_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_byte(digest_byte), .last_byte(last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[blake2s_hash_engine_top] ERROR");
				$finish;
			end
		end
	end

	function int pick_gap();
		if (calm) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
		return $urandom_range(8, 30);
	endfunction

	// receiver: hold ready low for random stretches
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(digest_byte, last_byte);
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	task send_item(action_t act, logic [7:0] data);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= data;
		do @(posedge clk); while (!in_ready);
		sb.note_input(act, data);
		items_sent++;
	endtask

	// one-cycle write pulse
	task set_reg(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// drop valid and write enable, then wait for the engine to drain
	task settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wr_en <= 1'b0;
		do @(negedge clk); while (sb.digest_q.size() != 0 || !in_ready);
	endtask

	task hash_message(int len);
		for (int i = 0; i < len; i++) send_item(ACT_APPEND, 8'($urandom));
		send_item(ACT_FINISH, 8'($urandom));
		settle();
	endtask

	function logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	initial begin
		int len;
		sb = new();
		items_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_DIGEST_LEN;
		wr_data = 64'd0;
		in_valid = 1'b0;
		action = ACT_APPEND;
		data_byte = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty message at reset settings
		hash_message(0);
		// single extreme bytes
		send_item(ACT_APPEND, 8'h00);
		send_item(ACT_FINISH, 8'hFF);
		settle();
		send_item(ACT_APPEND, 8'hFF);
		send_item(ACT_FINISH, 8'h00);
		settle();
		// digest length zero saturates to one, full key, keyed empty message
		set_reg(REG_DIGEST_LEN, 64'd0);
		set_reg(REG_KEY_LEN, 64'd32);
		set_reg(REG_KEY_0, 64'hFFFF_FFFF_FFFF_FFFF);
		set_reg(REG_KEY_1, rand64());
		set_reg(REG_KEY_2, rand64());
		set_reg(REG_KEY_3, 64'd0);
		set_reg(REG_UNUSED_6, rand64());
		set_reg(REG_UNUSED_7, rand64());
		hash_message(0);
		// oversize lengths saturate to 32
		set_reg(REG_DIGEST_LEN, 64'd63);
		set_reg(REG_KEY_LEN, 64'd63);
		hash_message(3);
		set_reg(REG_DIGEST_LEN, 64'hFFFF_FFFF_FFFF_FFE1);
		set_reg(REG_KEY_LEN, 64'd1);
		hash_message(2);

		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0: set_reg(REG_DIGEST_LEN, 64'($urandom_range(0, 63)));
					1: set_reg(REG_DIGEST_LEN, ($urandom_range(0, 1) == 0) ? 64'd1 : 64'd32);
					2: set_reg(REG_KEY_LEN, 64'($urandom_range(0, 63)));
					3: set_reg(REG_KEY_LEN, ($urandom_range(0, 1) == 0) ? 64'd0 : 64'd32);
					4: set_reg(3'($urandom_range(REG_KEY_0, REG_KEY_3)), rand64());
					default: set_reg(3'($urandom_range(0, 7)), rand64());
				endcase
				if ($urandom_range(0, 1) == 0)
					set_reg(REG_DIGEST_LEN, 64'($urandom_range(1, 32)));
			end
			case ($urandom_range(0, 19))
				0, 1, 2:     len = $urandom_range(60, 70);
				3, 4:        len = $urandom_range(126, 130);
				5, 6, 7, 8:  len = $urandom_range(13, 40);
				default:     len = $urandom_range(0, 12);
			endcase
			hash_message(len);
		end

		calm = 1'b0;
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.digest_q.size() == 0) begin
			$display("[blake2s_hash_engine_top] OK");
		end else begin
			$display("[blake2s_hash_engine_top] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
